// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the page table block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/ptta_pkg.sv
// Package with the constants, types and codes of the page table block.
`timescale 1ns / 1ps
package ptta_pkg;

   localparam int ADDR_W        = 31;
   localparam int VIRTUAL_PAGES = 524288;
   localparam int PAGE_BYTES    = 4096;
   localparam int PHYS_PAGES    = 4096;

   localparam int OFF_W   = $clog2(PAGE_BYTES);
   localparam int VPN_W   = $clog2(VIRTUAL_PAGES);
   localparam int VADDR_PAGE_W = ADDR_W - OFF_W;
   localparam int RANGE_W = VADDR_PAGE_W + 1;
   localparam int PPN_W   = 13;
   localparam int PA_W    = 24;
   localparam int CFG_W   = 13;
   localparam int SUM_W   = CFG_W + 1;
   localparam int CSR_IDX_W = 1;
   localparam int STATUS_W  = 2;

   localparam logic [RANGE_W-1:0] VPN_LIMIT = RANGE_W'(VIRTUAL_PAGES);
   localparam logic [SUM_W-1:0]   PHYS_LIM  = SUM_W'(PHYS_PAGES);

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PAGES = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] FIRST_FREE_RESET  = CFG_W'(0);
   localparam logic [CFG_W-1:0] TOTAL_PAGES_RESET = CFG_W'(4096);

   typedef enum logic [STATUS_W-1:0] {
      RSP_HIT   = 2'd0,
      RSP_FREE  = 2'd1,
      RSP_REPL  = 2'd2,
      RSP_FAULT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_EVICT
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [PPN_W-1:0] page;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       clr_write;    // write an invalid entry at the clear pointer
      logic       capture;      // latch the request and read its entry
      logic       map_free;     // map the request page to the next free page
      logic       scan_load;    // start the victim scan at the low-water mark
      logic       scan_step;    // read the next entry of the scan
      logic       victim_take;  // latch the victim and invalidate its entry
      logic       map_evict;    // map the request page to the victim's page
      logic       rsp_fire;     // load the response registers
      status_type rsp_kind;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic in_range;
      logic hit;
      logic free_ok;
      logic any_mapped;
      logic victim_found;
   } sts_type;

endpackage

// File: hw/rtl/ptta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ptta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ptta_dp.sv
// Datapath of the page table block: table memory, counters and response registers.
`timescale 1ns / 1ps
module ptta_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  ptta_pkg::cmd_type              cmd,
   output ptta_pkg::sts_type              sts,
   input  logic [ptta_pkg::ADDR_W-1:0]    req_address,
   input  logic                           csr_write,
   input  logic [ptta_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptta_pkg::CFG_W-1:0]     csr_wdata,
   output logic                           rsp_valid,
   output logic [ptta_pkg::PA_W-1:0]      rsp_physical_address,
   output logic [ptta_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_invalidate_valid,
   output logic [ptta_pkg::VPN_W-1:0]     rsp_invalidate_page
);
   import ptta_pkg::*;

   logic [CFG_W-1:0]   first_free_ff, first_free_in;
   logic [CFG_W-1:0]   total_ff, total_in;
   logic [PPN_W-1:0]   alloc_ff, alloc_in;
   logic [VPN_W-1:0]   hint_ff, hint_in;
   logic [VPN_W-1:0]   clr_ptr_ff, clr_ptr_in;
   logic [VPN_W-1:0]   scan_ptr_ff, scan_ptr_in;
   logic [VPN_W-1:0]   chk_ptr_ff, chk_ptr_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [VPN_W-1:0]   vpage_ff, vpage_in;
   logic [OFF_W-1:0]   offset_ff, offset_in;
   logic               in_range_ff, in_range_in;
   logic [VPN_W-1:0]   victim_ff, victim_in;
   logic [PPN_W-1:0]   vict_page_ff, vict_page_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]    rsp_pa_ff, rsp_pa_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic               rsp_inv_valid_ff, rsp_inv_valid_in;
   logic [VPN_W-1:0]   rsp_inv_page_ff, rsp_inv_page_in;

   logic                    wr_en;
   logic [VPN_W-1:0]        wr_addr;
   entry_type               wr_entry;
   logic                    rd_en;
   logic [VPN_W-1:0]        rd_addr;
   logic [ENTRY_W-1:0]      rd_data;
   entry_type               rd_entry;

   logic [VADDR_PAGE_W-1:0] req_vpage_full;
   logic [SUM_W-1:0]        free_sum;
   logic [SUM_W-1:0]        limit;
   logic [PPN_W-1:0]        free_page;
   logic [VPN_W:0]          victim_next;
   logic [PPN_W-1:0]        rsp_page;
   logic [PPN_W+OFF_W-1:0]  pa_full;

   assign req_vpage_full = req_address[ADDR_W-1:OFF_W];
   assign rd_entry       = rd_data;

   // Free allocation limit and the page it would hand out.
   assign free_sum  = {1'b0, first_free_ff} + {1'b0, alloc_ff};
   assign limit     = ({1'b0, total_ff} < PHYS_LIM) ? {1'b0, total_ff} : PHYS_LIM;
   assign free_page = free_sum[PPN_W-1:0];
   assign victim_next = {1'b0, chk_ptr_ff} + (VPN_W + 1)'(1);

   ptta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (VIRTUAL_PAGES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_en   = cmd.clr_write | cmd.map_free | cmd.victim_take | cmd.map_evict;
      wr_addr = vpage_ff;
      if (cmd.clr_write) begin
         wr_addr = clr_ptr_ff;
      end else if (cmd.victim_take) begin
         wr_addr = chk_ptr_ff;
      end
      wr_entry = '0;
      if (cmd.map_free) begin
         wr_entry.valid = 1'b1;
         wr_entry.page  = free_page;
      end else if (cmd.map_evict) begin
         wr_entry.valid = 1'b1;
         wr_entry.page  = vict_page_ff;
      end
      rd_en   = cmd.capture | cmd.scan_step;
      rd_addr = cmd.capture ? req_vpage_full[VPN_W-1:0] : scan_ptr_ff;
   end

   always_comb begin
      sts.clr_last     = (clr_ptr_ff == '1);
      sts.in_range     = in_range_ff;
      sts.hit          = rd_entry.valid;
      sts.free_ok      = (free_sum < limit);
      sts.any_mapped   = (alloc_ff != '0);
      sts.victim_found = chk_vld_ff & rd_entry.valid;
   end

   // Configuration, counters and scan state.
   always_comb begin
      first_free_in = first_free_ff;
      total_in      = total_ff;
      if (csr_write && (csr_index == CSR_FIRST_FREE)) begin
         first_free_in = csr_wdata;
      end
      if (csr_write && (csr_index == CSR_TOTAL_PAGES)) begin
         total_in = csr_wdata;
      end

      clr_ptr_in = cmd.clr_write ? clr_ptr_ff + VPN_W'(1) : clr_ptr_ff;

      vpage_in    = vpage_ff;
      offset_in   = offset_ff;
      in_range_in = in_range_ff;
      if (cmd.capture) begin
         vpage_in    = req_vpage_full[VPN_W-1:0];
         offset_in   = req_address[OFF_W-1:0];
         in_range_in = ({1'b0, req_vpage_full} < VPN_LIMIT);
      end

      alloc_in = alloc_ff;
      hint_in  = hint_ff;
      if (cmd.map_free) begin
         alloc_in = alloc_ff + PPN_W'(1);
         hint_in  = (vpage_ff < hint_ff) ? vpage_ff : hint_ff;
      end
      if (cmd.map_evict) begin
         // The victim was the lowest mapped entry; the new mapping may sit lower.
         hint_in = ({1'b0, vpage_ff} < {1'b0, victim_ff} + (VPN_W + 1)'(1)) ?
                   vpage_ff : victim_ff + VPN_W'(1);
      end

      scan_ptr_in = scan_ptr_ff;
      chk_ptr_in  = chk_ptr_ff;
      chk_vld_in  = chk_vld_ff;
      if (cmd.scan_load) begin
         scan_ptr_in = hint_ff;
         chk_vld_in  = 1'b0;
      end else if (cmd.scan_step) begin
         scan_ptr_in = scan_ptr_ff + VPN_W'(1);
         chk_ptr_in  = scan_ptr_ff;
         chk_vld_in  = 1'b1;
      end else if (cmd.victim_take) begin
         chk_vld_in = 1'b0;
      end

      victim_in    = victim_ff;
      vict_page_in = vict_page_ff;
      if (cmd.victim_take) begin
         victim_in    = victim_next[VPN_W-1:0] - VPN_W'(1);
         vict_page_in = rd_entry.page;
      end
   end

   // Response word.
   always_comb begin
      case (cmd.rsp_kind)
         RSP_HIT:  rsp_page = rd_entry.page;
         RSP_FREE: rsp_page = free_page;
         RSP_REPL: rsp_page = vict_page_ff;
         default:  rsp_page = '0;
      endcase
      pa_full          = {rsp_page, offset_ff};
      rsp_valid_in     = cmd.rsp_fire;
      rsp_pa_in        = (cmd.rsp_kind == RSP_FAULT) ? '0 : pa_full[PA_W-1:0];
      rsp_status_in    = cmd.rsp_kind;
      rsp_inv_valid_in = (cmd.rsp_kind == RSP_REPL);
      rsp_inv_page_in  = (cmd.rsp_kind == RSP_REPL) ? victim_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_free_ff <= FIRST_FREE_RESET;
         total_ff      <= TOTAL_PAGES_RESET;
         alloc_ff      <= '0;
         hint_ff       <= '0;
         clr_ptr_ff    <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_free_ff <= first_free_in;
         total_ff      <= total_in;
         alloc_ff      <= alloc_in;
         hint_ff       <= hint_in;
         clr_ptr_ff    <= clr_ptr_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vpage_ff     <= vpage_in;
      offset_ff    <= offset_in;
      in_range_ff  <= in_range_in;
      scan_ptr_ff  <= scan_ptr_in;
      chk_ptr_ff   <= chk_ptr_in;
      victim_ff    <= victim_in;
      vict_page_ff <= vict_page_in;
      if (cmd.rsp_fire) begin
         rsp_pa_ff        <= rsp_pa_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_inv_valid_ff <= rsp_inv_valid_in;
         rsp_inv_page_ff  <= rsp_inv_page_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_invalidate_valid = rsp_inv_valid_ff;
   assign rsp_invalidate_page  = rsp_inv_page_ff;

endmodule

// File: hw/rtl/ptta_ctrl.sv
// Controller state machine of the page table block.
`timescale 1ns / 1ps
module ptta_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output ptta_pkg::cmd_type cmd,
   input  ptta_pkg::sts_type sts
);
   import ptta_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.in_range && !sts.hit && !sts.free_ok && sts.any_mapped) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (sts.victim_found) state_in = S_EVICT;
         end
         S_EVICT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.rsp_kind = RSP_FAULT;
      busy     = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
         end
         S_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         S_CHECK: begin
            if (!sts.in_range) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_kind = RSP_FAULT;
            end else if (sts.hit) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_kind = RSP_HIT;
            end else if (sts.free_ok) begin
               cmd.map_free = 1'b1;
               cmd.rsp_fire = 1'b1;
               cmd.rsp_kind = RSP_FREE;
            end else if (!sts.any_mapped) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_kind = RSP_FAULT;
            end else begin
               cmd.scan_load = 1'b1;
            end
         end
         S_SCAN: begin
            if (sts.victim_found) begin
               cmd.victim_take = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_EVICT: begin
            cmd.map_evict = 1'b1;
            cmd.rsp_fire  = 1'b1;
            cmd.rsp_kind  = RSP_REPL;
         end
         default: begin
            cmd = '0;
            cmd.rsp_kind = RSP_FAULT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/page_table_translate_allocate.sv
// Top level of the single-level page table with translation, allocation and replacement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  Channel   Ports                                   Handshake
//  -------   -------------------------------------   -----------------------------------
//  request   start, busy, req_address                word taken when start and not busy
//  response  rsp_valid, rsp_physical_address,        word shown for one cycle on rsp_valid
//            rsp_status, rsp_invalidate_valid/page
//  config    csr_write, csr_index, csr_wdata         register written when csr_write
//
//  After reset the block sweeps the whole page table memory, one entry per cycle, writing
//  invalid entries; busy stays high until the sweep is done. Configuration writes are
//  taken then. For a hit, a free allocation or a fault, the accept cycle reads the table
//  entry and the next cycle decides; rsp_valid is registered and rises in the cycle after
//  the decision, while a new word may already be accepted. A replacement scans the table
//  upward from a low-water mark, one entry per cycle through the single read port, until
//  it reaches the victim. The receiver cannot stall; every response is shown once.
module page_table_translate_allocate (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ptta_pkg::ADDR_W-1:0]    req_address,
   output logic                           rsp_valid,
   output logic [ptta_pkg::PA_W-1:0]      rsp_physical_address,
   output logic [ptta_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_invalidate_valid,
   output logic [ptta_pkg::VPN_W-1:0]     rsp_invalidate_page,
   input  logic                           csr_write,
   input  logic [ptta_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptta_pkg::CFG_W-1:0]     csr_wdata
);
   import ptta_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    accept;

   // The controller sequences each word; the datapath owns the table memory.
   ptta_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   ptta_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_address          (req_address),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_status           (rsp_status),
      .rsp_invalidate_valid (rsp_invalidate_valid),
      .rsp_invalidate_page  (rsp_invalidate_page)
   );

   assign accept = start & ~busy;

   // An accepted word keeps the block busy in the next cycle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   // Responses are never shown back to back.
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // Invalidation is reported exactly with a replacement.
   `ASSERT_IMPLY(a_inv_repl, clock, reset, rsp_valid,
      rsp_invalidate_valid == (rsp_status == RSP_REPL))
   // A fault carries a zero physical address.
   `ASSERT_IMPLY(a_fault_zero, clock, reset, rsp_valid && (rsp_status == RSP_FAULT),
      rsp_physical_address == '0)

endmodule
